// File: rtl/assert_macros.svh
// Assertion macros used by the parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/tclp_pkg.sv
// Package: phase codes, command codes, character constants and keyword table of the parser.
package tclp_pkg;

    localparam int CHAR_W   = 8;
    localparam int PHASE_W  = 4;
    localparam int CMD_W    = 4;
    localparam int ENERGY_W = 64;
    localparam int NUM_KW   = 5;
    localparam int KW_LEN_W = 3;
    localparam int KW_BYTES = 7;

    // Parser phases
    localparam logic [PHASE_W-1:0] PH_LINE_START = 4'd0;
    localparam logic [PHASE_W-1:0] PH_KEYWORD    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ARG_ONE    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_EQ_ARG1    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_EQ_ARG2    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_EN_ARG1    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_EN_FIRST   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_EN_NUM     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_SKIP       = 4'd8;

    // Command codes
    localparam logic [CMD_W-1:0] CT_IGNORE     = 4'd0;
    localparam logic [CMD_W-1:0] CT_IGNORE_EOF = 4'd1;
    localparam logic [CMD_W-1:0] CT_EOF        = 4'd2;
    localparam logic [CMD_W-1:0] CT_ERROR      = 4'd3;
    localparam logic [CMD_W-1:0] CT_DECLARE    = 4'd4;
    localparam logic [CMD_W-1:0] CT_REMOVE     = 4'd5;
    localparam logic [CMD_W-1:0] CT_VALID      = 4'd6;
    localparam logic [CMD_W-1:0] CT_EQUAL      = 4'd7;
    localparam logic [CMD_W-1:0] CT_GET_ENERGY = 4'd8;
    localparam logic [CMD_W-1:0] CT_SET_ENERGY = 4'd9;

    // Keyword slots
    localparam int KW_DECLARE = 0;
    localparam int KW_REMOVE  = 1;
    localparam int KW_VALID   = 2;
    localparam int KW_EQUAL   = 3;
    localparam int KW_ENERGY  = 4;

    // Characters
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SP    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CH_THREE = 8'h33;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

    localparam logic [KW_LEN_W-1:0] MAX_KEYWORD = 3'd7;
    localparam logic [NUM_KW-1:0]   KW_ALL      = 5'h1F;

    // Keyword text, left-aligned, first character in the top byte; slot 0 last.
    localparam logic [NUM_KW-1:0][KW_BYTES*CHAR_W-1:0] KW_TEXT = {
        {"ENERGY", 8'h00},
        {"EQUAL",  16'h0000},
        {"VALID",  16'h0000},
        {"REMOVE", 8'h00},
        "DECLARE"
    };

    localparam logic [NUM_KW-1:0][KW_LEN_W-1:0] KW_LEN = {3'd6, 3'd5, 3'd5, 3'd6, 3'd7};

    typedef struct packed {
        logic                kind;
        logic [CMD_W-1:0]    cmd_type;
        logic [1:0]          arg_index;
        logic [1:0]          digit;
        logic [ENERGY_W-1:0] energy;
    } t_result;

    function automatic logic [CHAR_W-1:0] kw_char(input int k, input logic [KW_LEN_W-1:0] idx);
        logic [KW_BYTES*CHAR_W-1:0] text;
        logic [CHAR_W-1:0]          ch;
        text = KW_TEXT[k];
        ch   = '0;
        for (int b = 0; b < KW_BYTES; b++) begin
            if (idx == KW_LEN_W'(b)) begin
                ch = text[(KW_BYTES-1-b)*CHAR_W +: CHAR_W];
            end
        end
        return ch;
    endfunction

endpackage

// File: rtl/text_command_line_parser_top.sv
// Top level of the line command parser: input register, parse step, result register.
`include "assert_macros.svh"

// Line command parser. One request carries one character byte in i_s_tdata, or, with
// i_s_tuser[0] high, the end-of-input mark. A line is DECLARE, REMOVE, VALID, EQUAL or
// ENERGY, a space, then arguments made of digits 0-3; ENERGY may add a decimal number
// (1 .. 2^64-1, no leading zero). Every argument digit gives a digit result (tuser = 0)
// as it arrives; every newline or end-of-input gives one command result (tuser = 1):
// the command kind, ignore for blank and '#' lines, error, or end of file. A number
// above 2^64-1 gives error. Throughput is one request per clock: the parse step for
// a character is a small phase update plus one 68-bit shift-add (times ten plus digit)
// with its overflow test, all between the input register and the result register.
// An accepted request sits in the input register; any result of it goes into the result
// register when it is empty or read. The result register lets the next character enter
// while a result waits; backpressure on the output stalls the input side only once
// both registers are full.
module text_command_line_parser_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [tclp_pkg::CHAR_W-1:0] i_s_tdata,   // [7:0] char_code
    input  logic [0:0]                  i_s_tuser,   // [0] end_of_input
    // result stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [71:0]                 o_m_tdata,   // [3:0] command_type, [5:4] arg_index,
                                                     // [7:6] digit, [71:8] energy
    output logic [0:0]                  o_m_tuser    // [0] kind
);
    import tclp_pkg::*;

    // ---------------- input register ----------------
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_eoi;

    // ---------------- parser state ----------------
    logic [PHASE_W-1:0]  r_phase,     n_phase;
    logic [NUM_KW-1:0]   r_match,     n_match;
    logic [KW_LEN_W-1:0] r_kw_len,    n_kw_len;
    logic                r_nonempty,  n_nonempty;
    logic [ENERGY_W-1:0] r_acc,       n_acc;
    logic                r_skip_kind, n_skip_kind;

    // ---------------- result register ----------------
    logic    r_out_valid;
    t_result r_out;

    // handshake
    logic w_adv, w_fire, w_in_accept;

    assign w_adv       = !r_out_valid || i_m_tready;
    assign w_fire      = r_in_valid && w_adv;
    assign o_s_tready  = !r_in_valid || w_fire;
    assign w_in_accept = i_s_tvalid && o_s_tready;

    // character classes
    logic [CHAR_W-1:0] c;
    logic w_is_letter, w_is_hist, w_is_dec, w_is_nz_dec;

    assign c           = r_in_char;
    assign w_is_letter = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    assign w_is_hist   = (c >= CH_ZERO && c <= CH_THREE);
    assign w_is_dec    = (c >= CH_ZERO && c <= CH_NINE);
    assign w_is_nz_dec = (c >= CH_ONE && c <= CH_NINE);

    // keyword candidates after this letter, and the lookup at the terminating space
    logic [NUM_KW-1:0] w_match_upd;
    logic              w_kw_found;
    logic [NUM_KW-1:0] w_kw_onehot;

    always_comb begin
        w_match_upd = r_match;
        for (int k = 0; k < NUM_KW; k++) begin
            if (r_kw_len >= KW_LEN[k] || kw_char(k, r_kw_len) != c) begin
                w_match_upd[k] = 1'b0;
            end
        end
    end

    always_comb begin
        w_kw_found  = 1'b0;
        w_kw_onehot = '0;
        for (int k = 0; k < NUM_KW; k++) begin
            if (!w_kw_found && r_match[k] && KW_LEN[k] == r_kw_len) begin
                w_kw_found     = 1'b1;
                w_kw_onehot[k] = 1'b1;
            end
        end
    end

    // energy: acc * 10 + digit, with exact overflow above 2^64-1
    logic [ENERGY_W+3:0] w_acc_next;
    logic                w_acc_ovf;

    assign w_acc_next = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                      + {{(ENERGY_W){1'b0}}, c[3:0]};
    assign w_acc_ovf  = |w_acc_next[ENERGY_W+3:ENERGY_W];

    // per-phase argument handling
    logic [CMD_W-1:0]   w_arg_done;
    logic [PHASE_W-1:0] w_arg_next;
    logic [1:0]         w_arg_idx;

    always_comb begin
        w_arg_idx = 2'd1;
        case (r_phase)
            PH_ARG_ONE: begin
                w_arg_done = r_match[KW_DECLARE] ? CT_DECLARE :
                             r_match[KW_REMOVE]  ? CT_REMOVE  : CT_VALID;
                w_arg_next = PH_SKIP;
            end
            PH_EQ_ARG1: begin
                w_arg_done = CT_ERROR;
                w_arg_next = PH_EQ_ARG2;
            end
            PH_EQ_ARG2: begin
                w_arg_done = CT_EQUAL;
                w_arg_next = PH_SKIP;
                w_arg_idx  = 2'd2;
            end
            PH_EN_ARG1: begin
                w_arg_done = CT_GET_ENERGY;
                w_arg_next = PH_EN_FIRST;
            end
            default: begin
                w_arg_done = CT_ERROR;
                w_arg_next = PH_SKIP;
            end
        endcase
    end

    // parse step
    t_result             w_res;
    logic                w_res_valid;
    logic                w_cmd_en;
    logic [CMD_W-1:0]    w_cmd_type;
    logic [ENERGY_W-1:0] w_cmd_energy;
    logic                w_skip_en;
    logic                w_skip_kind;

    always_comb begin
        n_phase      = r_phase;
        n_match      = r_match;
        n_kw_len     = r_kw_len;
        n_nonempty   = r_nonempty;
        n_acc        = r_acc;
        n_skip_kind  = r_skip_kind;
        w_res        = '0;
        w_res_valid  = 1'b0;
        w_cmd_en     = 1'b0;
        w_cmd_type   = CT_IGNORE;
        w_cmd_energy = '0;
        w_skip_en    = 1'b0;
        w_skip_kind  = 1'b1;

        if (r_in_eoi) begin
            w_cmd_en   = 1'b1;
            w_cmd_type = (r_phase == PH_SKIP && !r_skip_kind) ? CT_IGNORE_EOF : CT_EOF;
        end else begin
            case (r_phase)
                PH_LINE_START, PH_KEYWORD: begin
                    if (r_phase == PH_LINE_START && c == CH_NL) begin
                        w_cmd_en   = 1'b1;
                        w_cmd_type = CT_IGNORE;
                    end else if (r_phase == PH_LINE_START && c == CH_HASH) begin
                        w_skip_en   = 1'b1;
                        w_skip_kind = 1'b0;
                    end else if (r_phase == PH_LINE_START && !w_is_letter) begin
                        w_skip_en = 1'b1;
                    end else if (w_is_letter) begin
                        // state already holds line-start values on the first letter
                        if (r_kw_len >= MAX_KEYWORD) begin
                            w_skip_en = 1'b1;
                        end else begin
                            n_match  = w_match_upd;
                            n_kw_len = r_kw_len + 1'b1;
                            n_phase  = PH_KEYWORD;
                        end
                    end else if (c == CH_NL) begin
                        w_cmd_en   = 1'b1;
                        w_cmd_type = CT_ERROR;
                    end else if (c != CH_SP || !w_kw_found) begin
                        w_skip_en = 1'b1;
                    end else begin
                        n_match    = w_kw_onehot;
                        n_nonempty = 1'b0;
                        if (w_kw_onehot[KW_EQUAL]) begin
                            n_phase = PH_EQ_ARG1;
                        end else if (w_kw_onehot[KW_ENERGY]) begin
                            n_phase = PH_EN_ARG1;
                        end else begin
                            n_phase = PH_ARG_ONE;
                        end
                    end
                end
                PH_ARG_ONE, PH_EQ_ARG1, PH_EQ_ARG2, PH_EN_ARG1: begin
                    if (w_is_hist) begin
                        n_nonempty      = 1'b1;
                        w_res_valid     = 1'b1;
                        w_res.arg_index = w_arg_idx;
                        w_res.digit     = c[1:0];
                    end else if (c == CH_NL) begin
                        w_cmd_en   = 1'b1;
                        w_cmd_type = r_nonempty ? w_arg_done : CT_ERROR;
                    end else if (c == CH_SP && w_arg_next != PH_SKIP && r_nonempty) begin
                        n_phase    = w_arg_next;
                        n_nonempty = 1'b0;
                    end else begin
                        w_skip_en = 1'b1;
                    end
                end
                PH_EN_FIRST: begin
                    if (w_is_nz_dec) begin
                        n_acc   = {{(ENERGY_W-4){1'b0}}, c[3:0]};
                        n_phase = PH_EN_NUM;
                    end else if (c == CH_NL) begin
                        w_cmd_en   = 1'b1;
                        w_cmd_type = CT_ERROR;
                    end else begin
                        w_skip_en = 1'b1;
                    end
                end
                PH_EN_NUM: begin
                    if (w_is_dec) begin
                        if (w_acc_ovf) begin
                            w_skip_en = 1'b1;
                        end else begin
                            n_acc = w_acc_next[ENERGY_W-1:0];
                        end
                    end else if (c == CH_NL) begin
                        w_cmd_en     = 1'b1;
                        w_cmd_type   = CT_SET_ENERGY;
                        w_cmd_energy = r_acc;
                    end else begin
                        w_skip_en = 1'b1;
                    end
                end
                default: begin
                    // skipped line; stray codes fold into it
                    if (c == CH_NL) begin
                        w_cmd_en   = 1'b1;
                        w_cmd_type = r_skip_kind ? CT_ERROR : CT_IGNORE;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            endcase
        end

        if (w_skip_en) begin
            n_phase     = PH_SKIP;
            n_skip_kind = w_skip_kind;
        end

        // a command closes the line and restarts the parser
        if (w_cmd_en) begin
            w_res_valid    = 1'b1;
            w_res.kind     = 1'b1;
            w_res.cmd_type = w_cmd_type;
            w_res.energy   = w_cmd_energy;
            n_phase        = PH_LINE_START;
            n_match        = KW_ALL;
            n_kw_len       = '0;
            n_nonempty     = 1'b0;
            n_acc          = '0;
            n_skip_kind    = 1'b0;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_char <= i_s_tdata;
            r_in_eoi  <= i_s_tuser[0];
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LINE_START;
            r_match     <= KW_ALL;
            r_kw_len    <= '0;
            r_nonempty  <= 1'b0;
            r_acc       <= '0;
            r_skip_kind <= 1'b0;
        end else if (w_fire) begin
            r_phase     <= n_phase;
            r_match     <= n_match;
            r_kw_len    <= n_kw_len;
            r_nonempty  <= n_nonempty;
            r_acc       <= n_acc;
            r_skip_kind <= n_skip_kind;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fire && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = {r_out.energy, r_out.digit, r_out.arg_index, r_out.cmd_type};
    assign o_m_tuser[0] = r_out.kind;

    // ---------------- assertions ----------------
    `ASSERT_NEXT(a_cmd_restarts_line, i_clk, i_rst_n, w_fire && w_cmd_en,
                 r_phase == PH_LINE_START && r_acc == '0 && r_match == KW_ALL)
    `ASSERT_IMPLIES(a_digit_arg_index, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[0],
                    o_m_tdata[5:4] == 2'd1 || o_m_tdata[5:4] == 2'd2)
    `ASSERT_IMPLIES(a_energy_only_set, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[71:8] != '0,
                    o_m_tuser[0] && o_m_tdata[3:0] == CT_SET_ENERGY)
    `ASSERT_NEXT(a_pending_item_kept, i_clk, i_rst_n, r_in_valid && !w_fire, r_in_valid)

endmodule
